[rtl/core/bfd_pkg.sv]
// ----------------------------------------------------------------------------
// bfd_pkg
// Shared constants, command type and lane arithmetic for the 2x2 box filter
// downsampler.
// ----------------------------------------------------------------------------
package bfd_pkg;

  localparam int unsigned MaxWidth  = 4096;
  localparam int unsigned MaxHeight = 4096;
  localparam int unsigned LineDepth = (MaxWidth + 1) / 2;
  localparam int unsigned LineAw    = $clog2(LineDepth);
  localparam int unsigned ColW      = $clog2(MaxWidth);
  localparam int unsigned RowW      = $clog2(MaxHeight);

  localparam int unsigned CfgW    = 13;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned BppW    = 3;
  localparam int unsigned PixW    = 32;
  localparam int unsigned Lanes   = 4;
  localparam int unsigned LaneW   = 9;
  localparam int unsigned PairW   = Lanes * LaneW;

  localparam int unsigned CmdDepth = 4;
  localparam int unsigned CmdAw    = $clog2(CmdDepth);
  localparam int unsigned OutDepth = 4;
  localparam int unsigned OutAw    = $clog2(OutDepth);

  localparam logic [CfgIdxW-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_BPP    = 2'd2;

  // one horizontal pair, ready for the line stores
  typedef struct packed {
    logic [PairW-1:0]  pair;
    logic [LineAw-1:0] addr;
    logic              odd_row;
    logic              top_row;
    logic              emit;
    logic              last;
  } cmd_t;

  // four 8-bit channels into 9-bit lanes
  function automatic logic [PairW-1:0] spread(input logic [PixW-1:0] px);
    logic [PairW-1:0] r;
    r = '0;
    for (int k = 0; k < Lanes; k++) begin
      r[k*LaneW +: LaneW] = {1'b0, px[k*8 +: 8]};
    end
    return r;
  endfunction

  // lane-wise sum of two pair sums, divided by four
  function automatic logic [PixW-1:0] combine(input logic [PairW-1:0] a,
                                              input logic [PairW-1:0] b);
    logic [PixW-1:0]  r;
    logic [LaneW:0]   s;
    r = '0;
    for (int k = 0; k < Lanes; k++) begin
      s = {1'b0, a[k*LaneW +: LaneW]} + {1'b0, b[k*LaneW +: LaneW]};
      r[k*8 +: 8] = s[9:2];
    end
    return r;
  endfunction

endpackage

[rtl/core/bfd_ram.sv]
// ----------------------------------------------------------------------------
// bfd_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module bfd_ram #(
  parameter int unsigned Width = 36,
  parameter int unsigned Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/bfd_front.sv]
// ----------------------------------------------------------------------------
// bfd_front
// Configuration registers, raster position and horizontal pairing; issues
// one command per completed pair.
// ----------------------------------------------------------------------------
module bfd_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bfd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [bfd_pkg::CfgW-1:0]    cfg_data_i,
  input  logic                        accept_i,
  input  logic [bfd_pkg::PixW-1:0]    in_pixel_i,
  output logic                        cmd_push_o,
  output bfd_pkg::cmd_t               cmd_o
);

  logic [bfd_pkg::ColW-1:0] w_last_q, w_last_d;
  logic [bfd_pkg::RowW-1:0] h_last_q, h_last_d;
  logic [1:0]               bpp_code_q, bpp_code_d;
  logic [bfd_pkg::ColW-1:0] col_q, col_d;
  logic [bfd_pkg::RowW-1:0] row_q, row_d;
  logic [bfd_pkg::PixW-1:0] held_q, held_d;
  logic [bfd_pkg::PixW-1:0] first_q, first_d;

  logic [bfd_pkg::PixW-1:0] mask;
  logic [bfd_pkg::PixW-1:0] px;
  logic [bfd_pkg::PixW-1:0] first_cur;
  logic                     col_odd;
  logic                     col_end;
  logic                     row_end;
  logic                     have_pair;
  logic [bfd_pkg::BppW-1:0] bpp_val;

  always_comb begin
    for (int k = 0; k < bfd_pkg::Lanes; k++) begin
      mask[k*8 +: 8] = (2'(k) <= bpp_code_q) ? 8'hFF : 8'h00;
    end
  end

  assign px        = in_pixel_i & mask;
  assign col_odd   = col_q[0];
  assign col_end   = (col_q == w_last_q);
  assign row_end   = (row_q == h_last_q);
  assign first_cur = (col_q == '0) ? px : first_q;
  assign have_pair = col_odd || col_end;
  assign bpp_val   = cfg_data_i[bfd_pkg::BppW-1:0];

  always_comb begin
    cmd_o.pair    = col_odd ? (bfd_pkg::spread(held_q) + bfd_pkg::spread(px))
                            : (bfd_pkg::spread(px) + bfd_pkg::spread(first_cur));
    cmd_o.addr    = col_q[bfd_pkg::ColW-1:1];
    cmd_o.odd_row = row_q[0];
    cmd_o.top_row = (row_q == '0);
    cmd_o.emit    = row_q[0] || row_end;
    cmd_o.last    = row_end && col_end;
  end

  assign cmd_push_o = accept_i && have_pair;

  always_comb begin
    w_last_d   = w_last_q;
    h_last_d   = h_last_q;
    bpp_code_d = bpp_code_q;
    col_d      = col_q;
    row_d      = row_q;
    held_d     = held_q;
    first_d    = first_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        bfd_pkg::CFG_WIDTH: begin
          if (cfg_data_i == '0) begin
            w_last_d = '0;
          end else if (cfg_data_i > bfd_pkg::CfgW'(bfd_pkg::MaxWidth)) begin
            w_last_d = bfd_pkg::ColW'(bfd_pkg::MaxWidth - 1);
          end else begin
            w_last_d = bfd_pkg::ColW'(cfg_data_i - 1'b1);
          end
        end
        bfd_pkg::CFG_HEIGHT: begin
          if (cfg_data_i == '0) begin
            h_last_d = '0;
          end else if (cfg_data_i > bfd_pkg::CfgW'(bfd_pkg::MaxHeight)) begin
            h_last_d = bfd_pkg::RowW'(bfd_pkg::MaxHeight - 1);
          end else begin
            h_last_d = bfd_pkg::RowW'(cfg_data_i - 1'b1);
          end
        end
        bfd_pkg::CFG_BPP: begin
          if (bpp_val == '0) begin
            bpp_code_d = 2'd0;
          end else if (bpp_val >= 3'd4) begin
            bpp_code_d = 2'd3;
          end else begin
            bpp_code_d = 2'(bpp_val - 1'b1);
          end
        end
        default: begin
        end
      endcase
      // any known register restarts the frame
      if (cfg_index_i == bfd_pkg::CFG_WIDTH || cfg_index_i == bfd_pkg::CFG_HEIGHT ||
          cfg_index_i == bfd_pkg::CFG_BPP) begin
        col_d = '0;
        row_d = '0;
      end
    end else if (accept_i) begin
      first_d = first_cur;
      if (!col_odd) begin
        held_d = px;
      end
      if (col_end) begin
        col_d = '0;
        row_d = row_end ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_last_q   <= bfd_pkg::ColW'(63);
      h_last_q   <= bfd_pkg::RowW'(63);
      bpp_code_q <= 2'd3;
      col_q      <= '0;
      row_q      <= '0;
      held_q     <= '0;
      first_q    <= '0;
    end else begin
      w_last_q   <= w_last_d;
      h_last_q   <= h_last_d;
      bpp_code_q <= bpp_code_d;
      col_q      <= col_d;
      row_q      <= row_d;
      held_q     <= held_d;
      first_q    <= first_d;
    end
  end

endmodule

[rtl/core/bfd_cmd_queue.sv]
// ----------------------------------------------------------------------------
// bfd_cmd_queue
// Short queue of pair commands between the front and the back.
// ----------------------------------------------------------------------------
module bfd_cmd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  bfd_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output bfd_pkg::cmd_t cmd_o
);

  bfd_pkg::cmd_t              slot_q [bfd_pkg::CmdDepth];
  logic [bfd_pkg::CmdAw-1:0]  wr_q, wr_d;
  logic [bfd_pkg::CmdAw-1:0]  rd_q, rd_d;
  logic [bfd_pkg::CmdAw:0]    cnt_q, cnt_d;
  logic                       do_push;
  logic                       do_pop;

  assign full_o  = (cnt_q == (bfd_pkg::CmdAw+1)'(bfd_pkg::CmdDepth));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = slot_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = do_push ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (bfd_pkg::CmdAw+1)'(do_push) - (bfd_pkg::CmdAw+1)'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

[rtl/core/bfd_back.sv]
// ----------------------------------------------------------------------------
// bfd_back
// Line stores, vertical combine and result queue.
// ----------------------------------------------------------------------------
module bfd_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cmd_valid_i,
  input  bfd_pkg::cmd_t            cmd_i,
  output logic                     cmd_pop_o,
  input  logic                     pop,
  output logic                     empty,
  output logic [bfd_pkg::PixW-1:0] out_pixel_o,
  output logic                     out_last_o
);

  logic                      issue;
  logic [bfd_pkg::PairW-1:0] even_rdata;
  logic [bfd_pkg::PairW-1:0] top_rdata;

  logic                      b_valid_q;
  logic [bfd_pkg::PairW-1:0] b_pair_q;
  logic                      b_odd_q;
  logic                      b_top_q;
  logic                      b_emit_q;
  logic                      b_last_q;
  logic [bfd_pkg::PairW-1:0] other;
  logic [bfd_pkg::PixW-1:0]  result;

  logic [bfd_pkg::PixW-1:0]  res_pix_q  [bfd_pkg::OutDepth];
  logic                      res_last_q [bfd_pkg::OutDepth];
  logic [bfd_pkg::OutAw-1:0] wr_q;
  logic [bfd_pkg::OutAw-1:0] rd_q;
  logic [bfd_pkg::OutAw:0]   cnt_q, cnt_d;
  logic [bfd_pkg::OutAw:0]   committed;
  logic                      res_push;
  logic                      res_pop;

  // room for the item in the combine stage and the one issued now
  assign committed = cnt_q + (bfd_pkg::OutAw+1)'(b_valid_q);
  assign issue     = cmd_valid_i && (committed < (bfd_pkg::OutAw+1)'(bfd_pkg::OutDepth));
  assign cmd_pop_o = issue;

  bfd_ram #(
    .Width (bfd_pkg::PairW),
    .Depth (bfd_pkg::LineDepth)
  ) u_even_ram (
    .clk_i   (clk_i),
    .we_i    (issue && !cmd_i.odd_row),
    .waddr_i (cmd_i.addr),
    .wdata_i (cmd_i.pair),
    .re_i    (issue),
    .raddr_i (cmd_i.addr),
    .rdata_o (even_rdata)
  );

  bfd_ram #(
    .Width (bfd_pkg::PairW),
    .Depth (bfd_pkg::LineDepth)
  ) u_top_ram (
    .clk_i   (clk_i),
    .we_i    (issue && !cmd_i.odd_row && cmd_i.top_row),
    .waddr_i (cmd_i.addr),
    .wdata_i (cmd_i.pair),
    .re_i    (issue),
    .raddr_i (cmd_i.addr),
    .rdata_o (top_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else begin
      b_valid_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      b_pair_q <= cmd_i.pair;
      b_odd_q  <= cmd_i.odd_row;
      b_top_q  <= cmd_i.top_row;
      b_emit_q <= cmd_i.emit;
      b_last_q <= cmd_i.last;
    end
  end

  // single-row image pairs the top row with itself
  always_comb begin
    priority if (b_odd_q) begin
      other = even_rdata;
    end else if (b_top_q) begin
      other = b_pair_q;
    end else begin
      other = top_rdata;
    end
  end

  assign result   = bfd_pkg::combine(b_pair_q, other);
  assign res_push = b_valid_q && b_emit_q;
  assign res_pop  = pop && !empty;
  assign cnt_d    = cnt_q + (bfd_pkg::OutAw+1)'(res_push) - (bfd_pkg::OutAw+1)'(res_pop);

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      res_pix_q[wr_q]  <= result;
      res_last_q[wr_q] <= b_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (res_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (res_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

  assign empty       = (cnt_q == '0);
  assign out_pixel_o = res_pix_q[rd_q];
  assign out_last_o  = res_last_q[rd_q];

endmodule

[rtl/core/box_filter_half_downsampler.sv]
// ----------------------------------------------------------------------------
// box_filter_half_downsampler
// 2x2 box filter mipmap reduction of a raster pixel stream.
// ----------------------------------------------------------------------------
// throughput: one pixel per cycle in unless full, one result per cycle out
//   unless empty, set by the single write and read port of each line store
// path: the command that completes a result passes the command queue, the
//   combine stage and the result queue before the result shows on the output
// reset: frame position, held pixels and queues clear; registers return to
//   64 x 64 at four channels; line store contents stay undefined
module box_filter_half_downsampler (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bfd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [bfd_pkg::CfgW-1:0]    cfg_data_i,
  input  logic                        push,
  output logic                        full,
  input  logic [bfd_pkg::PixW-1:0]    in_pixel_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [bfd_pkg::PixW-1:0]    out_pixel_o,
  output logic                        out_last_o
);

  logic          accept;
  logic          cmd_push;
  bfd_pkg::cmd_t cmd_in;
  bfd_pkg::cmd_t cmd_head;
  logic          cmd_valid;
  logic          cmd_pop;

  assign accept = push && !full;

  bfd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .in_pixel_i  (in_pixel_i),
    .cmd_push_o  (cmd_push),
    .cmd_o       (cmd_in)
  );

  bfd_cmd_queue u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .cmd_i   (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .valid_o (cmd_valid),
    .cmd_o   (cmd_head)
  );

  bfd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_head),
    .cmd_pop_o   (cmd_pop),
    .pop         (pop),
    .empty       (empty),
    .out_pixel_o (out_pixel_o),
    .out_last_o  (out_last_o)
  );

endmodule

[rtl/core/bfd_checker.sv]
// ----------------------------------------------------------------------------
// bfd_checker
// Port-level checks for the box filter downsampler, bound to the top level.
// ----------------------------------------------------------------------------
module bfd_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        cfg_we_i,
  input logic [bfd_pkg::CfgIdxW-1:0] cfg_index_i,
  input logic [bfd_pkg::CfgW-1:0]    cfg_data_i,
  input logic                        push,
  input logic                        full,
  input logic                        empty,
  input logic                        pop,
  input logic [bfd_pkg::PixW-1:0]    out_pixel_o,
  input logic                        out_last_o
);

  logic seen_q;
  logic one_chan_q;
  logic [bfd_pkg::BppW-1:0] bpp_val;

  assign bpp_val = cfg_data_i[bfd_pkg::BppW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q     <= 1'b0;
      one_chan_q <= 1'b0;
    end else begin
      if (push && !full) begin
        seen_q <= 1'b1;
      end
      if (cfg_we_i && cfg_index_i == bfd_pkg::CFG_BPP) begin
        one_chan_q <= (bpp_val == 3'd0) || (bpp_val == 3'd1);
      end
    end
  end

  // queues come out of reset empty and open
  a_reset_state: assert property (@(posedge clk_i) !rst_ni |=> empty && !full)
    else $error("queues not cleared by reset");

  // no result before any pixel was taken
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> seen_q)
    else $error("result without input");

  // input side cannot back up without input
  a_no_early_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> seen_q)
    else $error("full without input");

  // waiting result holds
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(out_pixel_o) && $stable(out_last_o))
    else $error("waiting result changed");

  // single channel leaves the upper bytes zero
  a_unused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && one_chan_q |-> out_pixel_o[31:8] == 24'd0)
    else $error("unused channel not zero");

endmodule

bind box_filter_half_downsampler bfd_checker u_bfd_checker (.*);

[tb/sv/box_filter_half_downsampler_test.sv]
// ----------------------------------------------------------------------------
// box_filter_half_downsampler_test
// Self-checking bench for the 2x2 box filter downsampler. Pixels go in through
// the push/full side and reduced pixels come out through the empty/pop side,
// both with random idle bursts. A predictor in the bench follows the frame
// position, the held pixels and both line stores, and each popped pixel is
// compared with the oldest predicted one. Sizes, channel counts and register
// saturation are swept between frames while the block is idle.
// ----------------------------------------------------------------------------
module box_filter_half_downsampler_test;

  // index past the register list
  localparam logic [bfd_pkg::CfgIdxW-1:0] CfgSpare = 2'd3;
  localparam int QuietLimit = 2000;
  localparam int SettleCycles = 8;
  localparam int RandomItems = 360;

  typedef struct {
    logic [bfd_pkg::PixW-1:0] pixel;
    logic                     last;
  } reduced_px_t;

  // follows the frame and predicts each reduced pixel
  class half_res_predictor;
    logic [bfd_pkg::CfgW-1:0]  width_reg;
    logic [bfd_pkg::CfgW-1:0]  height_reg;
    logic [bfd_pkg::BppW-1:0]  bpp_reg;
    int unsigned               col;
    int unsigned               row;
    logic [bfd_pkg::PixW-1:0]  held_px;
    logic [bfd_pkg::PixW-1:0]  first_px;
    logic [bfd_pkg::PairW-1:0] even_sums [bfd_pkg::LineDepth];
    logic [bfd_pkg::PairW-1:0] top_sums [bfd_pkg::LineDepth];
    reduced_px_t               avg_queue [$];
    int                        mismatches;

    function new();
      width_reg  = 13'd64;
      height_reg = 13'd64;
      bpp_reg    = 3'd4;
      col        = 0;
      row        = 0;
      held_px    = '0;
      first_px   = '0;
      mismatches = 0;
    endfunction

    function int unsigned eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > bfd_pkg::MaxWidth) return bfd_pkg::MaxWidth;
      return width_reg;
    endfunction

    function int unsigned eff_height();
      if (height_reg == 0) return 1;
      if (height_reg > bfd_pkg::MaxHeight) return bfd_pkg::MaxHeight;
      return height_reg;
    endfunction

    function logic [bfd_pkg::PixW-1:0] chan_mask();
      if (bpp_reg >= 4) return '1;
      if (bpp_reg == 0) return 32'h0000_00ff;
      return (32'h1 << (8 * bpp_reg)) - 32'h1;
    endfunction

    // bytes into 9-bit lanes so two pixels add without carry between channels
    function logic [bfd_pkg::PairW-1:0] widen(input logic [bfd_pkg::PixW-1:0] px);
      logic [bfd_pkg::PairW-1:0] r;
      r = '0;
      for (int k = 0; k < bfd_pkg::Lanes; k++) begin
        r[k*bfd_pkg::LaneW +: bfd_pkg::LaneW] = {1'b0, px[k*8 +: 8]};
      end
      return r;
    endfunction

    function logic [bfd_pkg::PixW-1:0] quarter(input logic [bfd_pkg::PairW-1:0] a,
                                               input logic [bfd_pkg::PairW-1:0] b);
      logic [bfd_pkg::PixW-1:0] r;
      logic [bfd_pkg::LaneW:0]  s;
      r = '0;
      for (int k = 0; k < bfd_pkg::Lanes; k++) begin
        s = {1'b0, a[k*bfd_pkg::LaneW +: bfd_pkg::LaneW]}
          + {1'b0, b[k*bfd_pkg::LaneW +: bfd_pkg::LaneW]};
        r[k*8 +: 8] = s[bfd_pkg::LaneW:2];
      end
      return r;
    endfunction

    function void set_reg(input logic [bfd_pkg::CfgIdxW-1:0] idx,
                          input logic [bfd_pkg::CfgW-1:0] data);
      case (idx)
        bfd_pkg::CFG_WIDTH: width_reg = data;
        bfd_pkg::CFG_HEIGHT: height_reg = data;
        bfd_pkg::CFG_BPP: bpp_reg = data[bfd_pkg::BppW-1:0];
        default: return;
      endcase
      col = 0;
      row = 0;
    endfunction

    function int pending();
      return avg_queue.size();
    endfunction

    function void take_pixel(input logic [bfd_pkg::PixW-1:0] in_px);
      int unsigned               w;
      int unsigned               h;
      int unsigned               j;
      logic [bfd_pkg::PixW-1:0]  px;
      logic [bfd_pkg::PairW-1:0] pair;
      bit                        have_pair;
      reduced_px_t               e;
      w = eff_width();
      h = eff_height();
      px = in_px & chan_mask();
      have_pair = 0;
      pair = '0;
      if (col == 0) first_px = px;
      if (col[0] == 1'b0) begin
        held_px = px;
        // odd width: last column pairs with column 0
        if (col == w - 1) begin
          pair = widen(px) + widen(first_px);
          have_pair = 1;
        end
      end else begin
        pair = widen(held_px) + widen(px);
        have_pair = 1;
      end
      if (have_pair) begin
        j = (col >> 1) % bfd_pkg::LineDepth;
        e.last = (row == h - 1) && (col == w - 1);
        if (row[0] == 1'b0) begin
          even_sums[j] = pair;
          if (row == 0) top_sums[j] = pair;
          // odd height: last row pairs with row 0
          if (row == h - 1) begin
            e.pixel = quarter(pair, top_sums[j]);
            avg_queue.insert(avg_queue.size(), e);
          end
        end else begin
          e.pixel = quarter(even_sums[j], pair);
          avg_queue.insert(avg_queue.size(), e);
        end
      end
      col++;
      if (col >= w) begin
        col = 0;
        row++;
        if (row >= h) row = 0;
      end
    endfunction

    task report(input string msg);
      $display("mismatch: %s", msg);
      mismatches++;
    endtask

    task check_pixel(input logic [bfd_pkg::PixW-1:0] got_px, input logic got_last);
      reduced_px_t e;
      if (avg_queue.size() == 0) begin
        report($sformatf("unexpected item out_pixel=%08h out_last=%0b", got_px, got_last));
      end else begin
        e = avg_queue.pop_front();
        if (got_px !== e.pixel)
          report($sformatf("out_pixel %08h, predicted %08h", got_px, e.pixel));
        if (got_last !== e.last)
          report($sformatf("out_last %0b, predicted %0b (pixel %08h)", got_last, e.last,
                           e.pixel));
      end
    endtask
  endclass

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        cfg_we_i = 1'b0;
  logic [bfd_pkg::CfgIdxW-1:0] cfg_index_i = '0;
  logic [bfd_pkg::CfgW-1:0]    cfg_data_i = '0;
  logic                        push = 1'b0;
  logic                        full;
  logic [bfd_pkg::PixW-1:0]    in_pixel_i = '0;
  logic                        empty;
  logic                        pop = 1'b0;
  logic [bfd_pkg::PixW-1:0]    out_pixel_o;
  logic                        out_last_o;

  half_res_predictor pred = new();

  bit calm = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  int stall_left = 0;
  int sent = 0;
  int quiet = 0;

  box_filter_half_downsampler DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .push       (push),
    .full       (full),
    .in_pixel_i (in_pixel_i),
    .empty      (empty),
    .pop        (pop),
    .out_pixel_o(out_pixel_o),
    .out_last_o (out_last_o)
  );

  always #5 clk_i = ~clk_i;

  // accepted items on both sides
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) pred.take_pixel(in_pixel_i);
      if (pop && !empty) pred.check_pixel(out_pixel_o, out_last_o);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QuietLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // output side stalls in random bursts
  always @(posedge clk_i) begin
    if (calm) begin
      pop <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      pop <= 1'b0;
    end else if ($urandom_range(99) < stall_pct) begin
      stall_left = $urandom_range(0, 17);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  task send_pixel(input logic [bfd_pkg::PixW-1:0] v);
    int gap;
    if (!calm && $urandom_range(99) < gap_pct) begin
      gap = $urandom_range(1, 18);
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    in_pixel_i <= v;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sent++;
  endtask

  // stop sending and wait until every predicted pixel has come out
  task settle();
    push <= 1'b0;
    @(posedge clk_i);
    while (pred.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task write_reg(input logic [bfd_pkg::CfgIdxW-1:0] idx,
                 input logic [bfd_pkg::CfgW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    pred.set_reg(idx, data);
  endtask

  // bpp_word carries the channel count in its low bits, the rest is don't-care
  task setup(input logic [bfd_pkg::CfgW-1:0] w, input logic [bfd_pkg::CfgW-1:0] h,
             input logic [bfd_pkg::CfgW-1:0] bpp_word, input int write_pct);
    if ($urandom_range(99) < write_pct) write_reg(bfd_pkg::CFG_WIDTH, w);
    if ($urandom_range(99) < write_pct) write_reg(bfd_pkg::CFG_HEIGHT, h);
    if ($urandom_range(99) < write_pct) write_reg(bfd_pkg::CFG_BPP, bpp_word);
    cfg_we_i <= 1'b0;
  endtask

  function logic [bfd_pkg::PixW-1:0] any_pixel();
    logic [bfd_pkg::PixW-1:0] p;
    p = $urandom();
    case ($urandom_range(9))
      0: p = '1;
      1: p = '0;
      2, 3: begin
        for (int k = 0; k < 4; k++) begin
          case ($urandom_range(2))
            0: p[k*8 +: 8] = 8'h00;
            1: p[k*8 +: 8] = 8'hff;
            default: ;
          endcase
        end
      end
      default: ;
    endcase
    return p;
  endfunction

  initial begin
    int unsigned w;
    int unsigned h;
    int unsigned n;
    int          start;
    logic [bfd_pkg::CfgW-1:0] bw;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    gap_pct = 15;
    stall_pct = 15;

    // register reset values: 64 x 64, four channels, two rows and one more pair
    repeat (130) send_pixel(any_pixel());
    settle();

    // width and height one, zero channels acts as one
    setup(13'd1, 13'd1, 13'd0, 100);
    send_pixel(32'hffff_ffff);
    send_pixel(32'h1234_5678);
    settle();

    // zero width and height saturate to one
    setup(13'd0, 13'd0, 13'd4, 100);
    send_pixel(32'hffff_ffff);
    send_pixel(32'h80ff_017f);
    settle();

    // odd width and height wrap to column 0 and row 0, seven channels acts as four
    setup(13'd3, 13'd3, 13'h1fff, 100);
    send_pixel(32'hffff_ffff);
    send_pixel(32'h0000_0000);
    send_pixel(32'hffff_ffff);
    send_pixel(32'h0101_0101);
    send_pixel(32'hfefe_fefe);
    send_pixel(32'h8080_8080);
    send_pixel(32'h7f7f_7f7f);
    send_pixel(32'h00ff_00ff);
    send_pixel(32'hff00_ff00);
    settle();

    // a write past the register list must not restart the frame
    setup(13'd2, 13'd2, 13'd2, 100);
    send_pixel(32'hffff_ffff);
    send_pixel(32'h0102_0304);
    settle();
    write_reg(CfgSpare, 13'h1fff);
    cfg_we_i <= 1'b0;
    send_pixel(32'hfffe_fdfc);
    send_pixel(32'h8000_0001);
    settle();

    // height one with one channel
    setup(13'd4, 13'd1, 13'd1, 100);
    send_pixel(32'hffff_ffff);
    send_pixel(32'hffff_ff00);
    send_pixel(32'h0000_00ff);
    send_pixel(32'h1234_5601);
    settle();

    // widest row, width saturates, only the first pixels of a height-one frame
    setup(13'h1fff, 13'd1, 13'd4, 100);
    repeat (64) send_pixel(any_pixel());
    settle();

    // tallest image, height saturates, only the first rows are sent
    setup(13'd1, 13'h1fff, 13'd3, 100);
    repeat (64) send_pixel(any_pixel());
    settle();

    start = sent;
    while (sent - start < RandomItems) begin
      case ($urandom_range(99) / 10)
        0: w = $urandom_range(0, 1);
        1, 2, 3, 4, 5, 6: w = $urandom_range(2, 8);
        default: w = $urandom_range(9, 40);
      endcase
      case ($urandom_range(99) / 10)
        0: h = $urandom_range(0, 1);
        1, 2, 3, 4, 5, 6, 7: h = $urandom_range(2, 8);
        default: h = $urandom_range(9, 16);
      endcase
      bw = 13'($urandom());
      bw[bfd_pkg::BppW-1:0] = 3'($urandom_range(0, 7));
      case ($urandom_range(2))
        0: gap_pct = 0;
        1: gap_pct = 10;
        default: gap_pct = 35;
      endcase
      case ($urandom_range(2))
        0: stall_pct = 0;
        1: stall_pct = 10;
        default: stall_pct = 35;
      endcase
      if (sent - start > RandomItems - 90) calm = 1;
      setup(13'(w), 13'(h), bw, 80);
      w = pred.eff_width();
      h = pred.eff_height();
      // mostly whole frames, some cut short by the next register write
      if ($urandom_range(4) == 0) n = $urandom_range(1, w * h);
      else if (w * h <= 100) n = w * h * $urandom_range(1, 2);
      else n = w * h;
      repeat (n) send_pixel(any_pixel());
      settle();
    end

    if (pred.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[box_filter_half_downsampler.f]
rtl/core/bfd_pkg.sv
rtl/core/bfd_ram.sv
rtl/core/bfd_front.sv
rtl/core/bfd_cmd_queue.sv
rtl/core/bfd_back.sv
rtl/core/box_filter_half_downsampler.sv
rtl/core/bfd_checker.sv
tb/sv/box_filter_half_downsampler_test.sv
